[rtl/core/psp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and command decode for the path segment point evaluator.
// Used by every module under rtl/core; depends on nothing.
package psp_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;

    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [T_BITS-1:0]            param_t;

    // ASCII command letters
    localparam logic [7:0] CMD_MARKER  = 8'h31; // '1'
    localparam logic [7:0] CMD_CUBIC_C = 8'h63; // 'c'
    localparam logic [7:0] CMD_CUBIC_S = 8'h73; // 's'
    localparam logic [7:0] CMD_CUBIC_UC = 8'h43; // 'C'
    localparam logic [7:0] CMD_CUBIC_US = 8'h53; // 'S'
    localparam logic [7:0] CMD_LINE_L  = 8'h6C; // 'l'
    localparam logic [7:0] CMD_LINE_H  = 8'h68; // 'h'
    localparam logic [7:0] CMD_LINE_V  = 8'h76; // 'v'
    localparam logic [7:0] CMD_LINE_Z  = 8'h7A; // 'z'
    localparam logic [7:0] CMD_LINE_UL = 8'h4C; // 'L'
    localparam logic [7:0] CMD_LINE_UZ = 8'h5A; // 'Z'
    localparam logic [7:0] CMD_MOVE_M  = 8'h6D; // 'm'
    localparam logic [7:0] CMD_MOVE_UM = 8'h4D; // 'M'

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MARKER  = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_CUBIC,
        KIND_LINE,
        KIND_MOVE,
        KIND_MARKER,
        KIND_UNKNOWN
    } kind_t;

    // Control that travels alongside the coordinates through the cell rows
    typedef struct packed {
        status_t status;
        logic    linear;
    } ctrl_t;

    typedef struct packed {
        logic [7:0] command_char;
        param_t     t;
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
        coord_t     x2;
        coord_t     y2;
        coord_t     x3;
        coord_t     y3;
    } in_t;

    typedef struct packed {
        coord_t  px;
        coord_t  py;
        status_t status;
    } out_t;

    function automatic kind_t decode_cmd(input logic [7:0] cmd);
        kind_t kind;
        case (cmd)
            CMD_MARKER: kind = KIND_MARKER;
            CMD_CUBIC_C, CMD_CUBIC_S, CMD_CUBIC_UC, CMD_CUBIC_US: kind = KIND_CUBIC;
            CMD_LINE_L, CMD_LINE_H, CMD_LINE_V, CMD_LINE_Z,
            CMD_LINE_UL, CMD_LINE_UZ: kind = KIND_LINE;
            CMD_MOVE_M, CMD_MOVE_UM: kind = KIND_MOVE;
            default: kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

[rtl/core/psp_lerp_cell.sv]
`timescale 1ns / 1ps
// One interpolation cell: registered, rounded lerp of a toward b by t.
// Depends on psp_pkg for coordinate and parameter types.
module psp_lerp_cell (
    input  logic             aclk,
    input  logic             en,
    input  psp_pkg::coord_t  a,
    input  psp_pkg::coord_t  b,
    input  psp_pkg::param_t  t,
    output psp_pkg::coord_t  q
);

    localparam int CB = psp_pkg::COORD_BITS;
    localparam int TF = psp_pkg::T_FRAC_BITS;
    localparam int PW = CB + TF + 3;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (TF - 1);

    logic signed [CB:0]   diff;
    logic signed [TF+1:0] t_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] scaled;
    logic signed [CB:0]   a_ext;
    logic signed [CB:0]   sum;
    psp_pkg::coord_t      q_reg;
    psp_pkg::coord_t      q_next;

    // a*(1-t) + b*t equals a + (b-a)*t; the a*ONE term leaves the rounding untouched
    always_comb begin
        a_ext  = {a[CB-1], a};
        diff   = {b[CB-1], b} - a_ext;
        t_s    = {1'b0, t};
        prod   = PW'(diff) * PW'(t_s);
        scaled = (prod + HALF) >>> TF;
        sum    = a_ext + scaled[CB:0];
        q_next = sum[CB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/psp_level.sv]
`timescale 1ns / 1ps
// One de Casteljau level: a row of lerp cells for x and y with its valid stage.
// Depends on psp_pkg and psp_lerp_cell.
module psp_level #(
    parameter int NPTS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  psp_pkg::coord_t in_x [NPTS],
    input  psp_pkg::coord_t in_y [NPTS],
    input  psp_pkg::param_t in_t,
    input  psp_pkg::ctrl_t  in_ctrl,
    output logic            out_valid,
    input  logic            out_ready,
    output psp_pkg::coord_t out_x [NPTS-1],
    output psp_pkg::coord_t out_y [NPTS-1],
    output psp_pkg::param_t out_t,
    output psp_pkg::ctrl_t  out_ctrl
);

    logic            valid_reg;
    logic            valid_next;
    psp_pkg::param_t t_reg;
    psp_pkg::ctrl_t  ctrl_reg;
    logic            en;

    // take a new transaction when empty or when the next stage drains this one
    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= in_t;
            ctrl_reg <= in_ctrl;
        end
    end

    for (genvar i = 0; i < NPTS - 1; i++) begin : g_cell
        psp_lerp_cell u_cell_x (
            .aclk (aclk),
            .en   (en),
            .a    (in_x[i]),
            .b    (in_x[i+1]),
            .t    (in_t),
            .q    (out_x[i])
        );
        psp_lerp_cell u_cell_y (
            .aclk (aclk),
            .en   (en),
            .a    (in_y[i]),
            .b    (in_y[i+1]),
            .t    (in_t),
            .q    (out_y[i])
        );
    end

    assign out_valid = valid_reg;
    assign out_t     = t_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

[rtl/core/path_segment_point_evaluator_unit.sv]
`timescale 1ns / 1ps
// Top level of the path segment point evaluator: command decode and three cell rows.
// Depends on psp_pkg, psp_level and psp_lerp_cell.
//
// Usage:
//   s_valid/s_ready/s_data carry one path segment per transaction: the command
//   letter, t in Q1.16 (values above 1.0 are clamped) and four control points.
//   m_valid/m_ready/m_data return one point and a status per segment, in order.
//   m_valid rises once the segment has been registered in level 1, level 2
//   and level 3; throughput is one segment per cycle while no stall holds
//   s_ready low. The three de Casteljau levels are three rows of lerp
//   cells, each row one pipeline stage with one multiplier per cell.
//   Line letters run the first row at t and the later rows at t = 0; move
//   letters run every row at t = 0; marker and unknown letters zero the points.
//   A stalled receiver holds the final stage; earlier stages keep filling
//   until they reach it, then s_ready drops. Reset empties all stages.
module path_segment_point_evaluator_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  psp_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output psp_pkg::out_t  m_data
);

    psp_pkg::kind_t  kind;
    psp_pkg::param_t t_sat;
    psp_pkg::param_t t0;
    psp_pkg::ctrl_t  ctrl0;
    psp_pkg::coord_t x0 [4];
    psp_pkg::coord_t y0 [4];

    psp_pkg::coord_t x1 [3];
    psp_pkg::coord_t y1 [3];
    psp_pkg::param_t t1;
    psp_pkg::param_t t1_use;
    psp_pkg::ctrl_t  ctrl1;
    logic            v1;
    logic            r1;

    psp_pkg::coord_t x2 [2];
    psp_pkg::coord_t y2 [2];
    psp_pkg::param_t t2;
    psp_pkg::param_t t2_use;
    psp_pkg::ctrl_t  ctrl2;
    logic            v2;
    logic            r2;

    psp_pkg::coord_t x3 [1];
    psp_pkg::coord_t y3 [1];
    psp_pkg::ctrl_t  ctrl3;

    always_comb begin
        kind  = psp_pkg::decode_cmd(s_data.command_char);
        t_sat = (s_data.t > psp_pkg::T_ONE) ? psp_pkg::T_ONE : s_data.t;
        x0[0] = s_data.x0;
        x0[1] = s_data.x1;
        x0[2] = s_data.x2;
        x0[3] = s_data.x3;
        y0[0] = s_data.y0;
        y0[1] = s_data.y1;
        y0[2] = s_data.y2;
        y0[3] = s_data.y3;
        t0             = t_sat;
        ctrl0.status   = psp_pkg::STATUS_OK;
        ctrl0.linear   = 1'b0;
        case (kind)
            psp_pkg::KIND_CUBIC: begin
            end
            psp_pkg::KIND_LINE: begin
                ctrl0.linear = 1'b1;
            end
            psp_pkg::KIND_MOVE: begin
                // at t = 0 every level returns its first point
                t0 = '0;
            end
            psp_pkg::KIND_MARKER: begin
                ctrl0.status = psp_pkg::STATUS_MARKER;
                t0           = '0;
                for (int i = 0; i < 4; i++) begin
                    x0[i] = '0;
                    y0[i] = '0;
                end
            end
            default: begin
                ctrl0.status = psp_pkg::STATUS_UNKNOWN;
                t0           = '0;
                for (int i = 0; i < 4; i++) begin
                    x0[i] = '0;
                    y0[i] = '0;
                end
            end
        endcase
    end

    psp_level #(.NPTS(4)) u_level1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (x0),
        .in_y      (y0),
        .in_t      (t0),
        .in_ctrl   (ctrl0),
        .out_valid (v1),
        .out_ready (r1),
        .out_x     (x1),
        .out_y     (y1),
        .out_t     (t1),
        .out_ctrl  (ctrl1)
    );

    // hold the line result: later levels pass their first point through
    assign t1_use = ctrl1.linear ? '0 : t1;

    psp_level #(.NPTS(3)) u_level2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_x      (x1),
        .in_y      (y1),
        .in_t      (t1_use),
        .in_ctrl   (ctrl1),
        .out_valid (v2),
        .out_ready (r2),
        .out_x     (x2),
        .out_y     (y2),
        .out_t     (t2),
        .out_ctrl  (ctrl2)
    );

    assign t2_use = ctrl2.linear ? '0 : t2;

    psp_level #(.NPTS(2)) u_level3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_x      (x2),
        .in_y      (y2),
        .in_t      (t2_use),
        .in_ctrl   (ctrl2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (x3),
        .out_y     (y3),
        .out_t     (),
        .out_ctrl  (ctrl3)
    );

    assign m_data.px     = x3[0];
    assign m_data.py     = y3[0];
    assign m_data.status = ctrl3.status;

endmodule
